// File: hw/rtl/nss_pkg.sv
// ============================================================================
// nss_pkg
// Shared constants and types for the nearest segment search block.
// ============================================================================
package nss_pkg;

    localparam int MAX_SEGMENTS_DEF  = 64;
    localparam int COORD_BITS_DEF    = 20;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int INDEX_BITS = 6;
    localparam int COUNT_BITS = 7;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Operation codes of an input item.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register index, taken from paddr[2].
    localparam logic REG_SEGMENT_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

// File: hw/rtl/nss_dist_pipe.sv
// ============================================================================
// nss_dist_pipe
// Pipelined point-to-segment squared distance, one segment in per cycle.
// ============================================================================
module nss_dist_pipe #(
    parameter int COORD_BITS    = nss_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = nss_pkg::FRACTION_BITS_DEF,
    parameter int ADDR_BITS     = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic [ADDR_BITS-1:0]          in_idx,
    input  logic signed [COORD_BITS-1:0]  in_sx,
    input  logic signed [COORD_BITS-1:0]  in_sy,
    input  logic signed [COORD_BITS-1:0]  in_ex,
    input  logic signed [COORD_BITS-1:0]  in_ey,
    input  logic signed [COORD_BITS-1:0]  in_px,
    input  logic signed [COORD_BITS-1:0]  in_py,
    output logic                          out_valid,
    output logic [ADDR_BITS-1:0]          out_idx,
    output logic signed [COORD_BITS-1:0]  out_sx,
    output logic signed [COORD_BITS-1:0]  out_sy,
    output logic signed [COORD_BITS-1:0]  out_ex,
    output logic signed [COORD_BITS-1:0]  out_ey,
    output logic [2*COORD_BITS+2:0]       out_dist,
    output logic                          busy
);

    localparam int C  = COORD_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int D  = C + 1;
    localparam int PW = 2 * D + 1;
    localparam int RW = PW + 1;
    localparam int TW = F + 1;
    localparam int MW = D + TW;
    localparam int E  = C + 2;
    localparam int DW = 2 * C + 3;
    localparam int NV = F + 9;

    typedef struct packed {
        logic [ADDR_BITS-1:0] idx;
        logic signed [C-1:0]  sx;
        logic signed [C-1:0]  sy;
        logic signed [C-1:0]  ex;
        logic signed [C-1:0]  ey;
        logic signed [C-1:0]  px;
        logic signed [C-1:0]  py;
        logic signed [D-1:0]  dx;
        logic signed [D-1:0]  dy;
    } carry_t;

    typedef struct packed {
        carry_t        c;
        logic [PW-1:0] len;
        logic [RW-1:0] r;
        logic [F-1:0]  q;
        logic          tz;
        logic          to;
    } div_t;

    logic [NV-1:0] v_reg;

    carry_t              c1_reg, c2_reg;
    logic signed [D-1:0] rx1_reg, ry1_reg;
    logic signed [2*D-1:0] dxx_reg, dyy_reg, rdx_reg, rdy_reg;
    div_t                dv_reg [F+1];
    carry_t              c4_reg, c5_reg, c6_reg, c7_reg, c8_reg;
    logic [TW-1:0]       t_reg;
    logic [MW-1:0]       mx_reg, my_reg;
    logic signed [E-1:0] cx_reg, cy_reg, ax_reg, ay_reg;
    logic signed [2*E-1:0] sqx_reg, sqy_reg;
    carry_t              co_reg;
    logic [DW-1:0]       dist_reg;

    // Combinational helpers.
    logic signed [PW-1:0] dot_c, len_s;
    logic [PW-1:0]        len_c;
    logic                 tz_c, to_c;
    logic [RW-1:0]        r_last2;
    logic [TW-1:0]        t_c;
    logic [MW-1:0]        half_c, rx_sum, ry_sum;
    logic signed [E-1:0]  offx_m, offy_m, offx_c, offy_c;
    logic [2*E:0]         dsum_c;

    always_comb begin
        dot_c = PW'(rdx_reg) + PW'(rdy_reg);
        len_s = PW'(dxx_reg) + PW'(dyy_reg);
        len_c = len_s;
        tz_c  = (len_c == '0) || (dot_c <= 0);
        to_c  = !tz_c && (unsigned'(dot_c) >= len_c);

        r_last2 = dv_reg[F].r << 1;
        if (dv_reg[F].tz) begin
            t_c = '0;
        end else if (dv_reg[F].to) begin
            t_c = TW'(1) << F;
        end else begin
            t_c = TW'(dv_reg[F].q) + TW'(r_last2 >= RW'(dv_reg[F].len));
        end

        half_c = MW'(1) << (F - 1);
        rx_sum = (mx_reg + half_c) >> F;
        ry_sum = (my_reg + half_c) >> F;
        offx_m = E'(rx_sum);
        offy_m = E'(ry_sum);
        offx_c = c5_reg.dx[D-1] ? -offx_m : offx_m;
        offy_c = c5_reg.dy[D-1] ? -offy_m : offy_m;

        dsum_c = (2*E+1)'(unsigned'(sqx_reg)) + (2*E+1)'(unsigned'(sqy_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[NV-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        // Differences.
        c1_reg.idx <= in_idx;
        c1_reg.sx  <= in_sx;
        c1_reg.sy  <= in_sy;
        c1_reg.ex  <= in_ex;
        c1_reg.ey  <= in_ey;
        c1_reg.px  <= in_px;
        c1_reg.py  <= in_py;
        c1_reg.dx  <= D'(in_ex) - D'(in_sx);
        c1_reg.dy  <= D'(in_ey) - D'(in_sy);
        rx1_reg    <= D'(in_px) - D'(in_sx);
        ry1_reg    <= D'(in_py) - D'(in_sy);

        // Products.
        c2_reg  <= c1_reg;
        dxx_reg <= c1_reg.dx * c1_reg.dx;
        dyy_reg <= c1_reg.dy * c1_reg.dy;
        rdx_reg <= rx1_reg * c1_reg.dx;
        rdy_reg <= ry1_reg * c1_reg.dy;

        // Classify the projection and load the divider.
        dv_reg[0].c   <= c2_reg;
        dv_reg[0].len <= len_c;
        dv_reg[0].r   <= (tz_c || to_c) ? '0 : RW'(unsigned'(dot_c));
        dv_reg[0].q   <= '0;
        dv_reg[0].tz  <= tz_c;
        dv_reg[0].to  <= to_c;

        // Restoring division, one quotient bit per stage.
        for (int k = 0; k < F; k++) begin
            logic [RW-1:0] r2;
            logic          ge;
            r2 = dv_reg[k].r << 1;
            ge = r2 >= RW'(dv_reg[k].len);
            dv_reg[k+1].c   <= dv_reg[k].c;
            dv_reg[k+1].len <= dv_reg[k].len;
            dv_reg[k+1].r   <= ge ? r2 - RW'(dv_reg[k].len) : r2;
            dv_reg[k+1].q   <= {dv_reg[k].q[F-2:0], ge};
            dv_reg[k+1].tz  <= dv_reg[k].tz;
            dv_reg[k+1].to  <= dv_reg[k].to;
        end

        // Rounded t and the offset magnitudes.
        c4_reg <= dv_reg[F].c;
        t_reg  <= t_c;
        c5_reg <= c4_reg;
        mx_reg <= MW'(c4_reg.dx[D-1] ? D'(-c4_reg.dx) : D'(c4_reg.dx)) * MW'(t_reg);
        my_reg <= MW'(c4_reg.dy[D-1] ? D'(-c4_reg.dy) : D'(c4_reg.dy)) * MW'(t_reg);

        // Closest point.
        c6_reg <= c5_reg;
        cx_reg <= E'(c5_reg.sx) + offx_c;
        cy_reg <= E'(c5_reg.sy) + offy_c;

        // Offset to the point, then squares and sum.
        c7_reg  <= c6_reg;
        ax_reg  <= E'(c6_reg.px) - cx_reg;
        ay_reg  <= E'(c6_reg.py) - cy_reg;
        c8_reg  <= c7_reg;
        sqx_reg <= ax_reg * ax_reg;
        sqy_reg <= ay_reg * ay_reg;
        co_reg   <= c8_reg;
        dist_reg <= DW'(dsum_c);
    end

    assign out_valid = v_reg[NV-1];
    assign out_idx   = co_reg.idx;
    assign out_sx    = co_reg.sx;
    assign out_sy    = co_reg.sy;
    assign out_ex    = co_reg.ex;
    assign out_ey    = co_reg.ey;
    assign out_dist  = dist_reg;
    assign busy      = |v_reg;

endmodule

// File: hw/rtl/nearest_segment_search.sv
// ============================================================================
// nearest_segment_search
// Nearest 2-D line segment to a query point over a table of segments.
// ============================================================================
// The input channel (s_*) carries two kinds of item. A write item stores
// one segment in the table slot given by s_entry_index and gives no result.
// A query item gives a point; the block searches the first segment_count
// table entries (at most MAX_SEGMENTS) and returns one result item on the m_*
// channel: the index and endpoints of the nearest segment and its squared
// distance, or found = 0 when the count is zero. Ties keep the earlier entry.
// segment_count is set through the APB port at byte address 0.
// The table memory is read once per cycle into a distance pipeline whose
// length is set by the bit-per-stage divider for t, and the running minimum
// is taken at the pipeline's end.
// One item is worked on at a time. The result sits in an output register,
// so a stalled receiver does not block write items; a second query result
// waits until the first has been taken.
// Reset clears segment_count and the control state. The table contents are
// undefined until written, and a query must search only written entries.
module nearest_segment_search #(
    parameter int MAX_SEGMENTS  = nss_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_BITS    = nss_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = nss_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input items
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_operation,
    input  logic [nss_pkg::INDEX_BITS-1:0]       s_entry_index,
    input  logic signed [COORD_BITS-1:0]         s_seg_start_x,
    input  logic signed [COORD_BITS-1:0]         s_seg_start_y,
    input  logic signed [COORD_BITS-1:0]         s_seg_end_x,
    input  logic signed [COORD_BITS-1:0]         s_seg_end_y,
    input  logic signed [COORD_BITS-1:0]         s_point_x,
    input  logic signed [COORD_BITS-1:0]         s_point_y,
    // Result items
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_found,
    output logic [nss_pkg::INDEX_BITS-1:0]       m_best_index,
    output logic signed [COORD_BITS-1:0]         m_best_start_x,
    output logic signed [COORD_BITS-1:0]         m_best_start_y,
    output logic signed [COORD_BITS-1:0]         m_best_end_x,
    output logic signed [COORD_BITS-1:0]         m_best_end_y,
    output logic [2*COORD_BITS+2:0]              m_best_distance_sq,
    // Configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [nss_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [nss_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [nss_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready
);

    localparam int C  = COORD_BITS;
    localparam int DW = 2 * C + 3;
    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int NW = $clog2(MAX_SEGMENTS + 1);

    nss_pkg::state_t state_reg, state_next;

    logic [nss_pkg::COUNT_BITS-1:0] count_reg;
    logic [NW-1:0]  n_reg, cnt_reg;
    logic signed [C-1:0] px_reg, py_reg;
    logic           issue_en;
    logic           issue_v_reg;
    logic [AW-1:0]  issue_idx_reg;
    logic [4*C-1:0] seg_mem [MAX_SEGMENTS];
    logic [4*C-1:0] rd_data_reg;

    logic           s_acc, query_acc, write_acc, cfg_wr, load_result;

    logic           p_valid, p_busy;
    logic [AW-1:0]  p_idx;
    logic signed [C-1:0] p_sx, p_sy, p_ex, p_ey;
    logic [DW-1:0]  p_dist;

    logic           best_have_reg;
    logic [AW-1:0]  best_idx_reg;
    logic signed [C-1:0] best_sx_reg, best_sy_reg, best_ex_reg, best_ey_reg;
    logic [DW-1:0]  best_d_reg;

    logic           m_valid_reg, m_found_reg;
    logic [nss_pkg::INDEX_BITS-1:0] m_idx_reg;
    logic signed [C-1:0] m_sx_reg, m_sy_reg, m_ex_reg, m_ey_reg;
    logic [DW-1:0]  m_d_reg;

    assign s_acc     = s_valid && s_ready;
    assign query_acc = s_acc && (s_operation == nss_pkg::OP_QUERY);
    assign write_acc = s_acc && (s_operation == nss_pkg::OP_WRITE)
                       && (int'(s_entry_index) < MAX_SEGMENTS);
    assign cfg_wr    = psel && penable && pwrite && pready;

    // Register file.
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[2] == nss_pkg::REG_SEGMENT_COUNT) begin
            prdata = nss_pkg::APB_DATA_BITS'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_wr && paddr[2] == nss_pkg::REG_SEGMENT_COUNT) begin
            count_reg <= pwdata[nss_pkg::COUNT_BITS-1:0];
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            nss_pkg::ST_IDLE: begin
                if (query_acc) state_next = nss_pkg::ST_ISSUE;
            end
            nss_pkg::ST_ISSUE: begin
                if (!(cnt_reg < n_reg)) state_next = nss_pkg::ST_DRAIN;
            end
            nss_pkg::ST_DRAIN: begin
                if (!p_busy) state_next = nss_pkg::ST_FINISH;
            end
            nss_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) state_next = nss_pkg::ST_IDLE;
            end
            default: state_next = nss_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = (state_reg == nss_pkg::ST_IDLE);
        issue_en    = (state_reg == nss_pkg::ST_ISSUE) && (cnt_reg < n_reg);
        load_result = (state_reg == nss_pkg::ST_FINISH) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nss_pkg::ST_IDLE;
            issue_v_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            issue_v_reg <= issue_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (query_acc) begin
            cnt_reg <= '0;
            px_reg  <= s_point_x;
            py_reg  <= s_point_y;
            if (int'(count_reg) > MAX_SEGMENTS) begin
                n_reg <= NW'(MAX_SEGMENTS);
            end else begin
                n_reg <= NW'(count_reg);
            end
        end else if (issue_en) begin
            cnt_reg <= cnt_reg + NW'(1);
        end
        issue_idx_reg <= cnt_reg[AW-1:0];
    end

    // Segment table: written by write items, read once per cycle by a query.
    always_ff @(posedge aclk) begin
        if (write_acc) begin
            seg_mem[AW'(s_entry_index)] <= {s_seg_start_x, s_seg_start_y,
                                            s_seg_end_x, s_seg_end_y};
        end
        if (issue_en) begin
            rd_data_reg <= seg_mem[cnt_reg[AW-1:0]];
        end
    end

    nss_dist_pipe #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .ADDR_BITS     (AW)
    ) u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (issue_v_reg),
        .in_idx    (issue_idx_reg),
        .in_sx     (rd_data_reg[4*C-1:3*C]),
        .in_sy     (rd_data_reg[3*C-1:2*C]),
        .in_ex     (rd_data_reg[2*C-1:C]),
        .in_ey     (rd_data_reg[C-1:0]),
        .in_px     (px_reg),
        .in_py     (py_reg),
        .out_valid (p_valid),
        .out_idx   (p_idx),
        .out_sx    (p_sx),
        .out_sy    (p_sy),
        .out_ex    (p_ex),
        .out_ey    (p_ey),
        .out_dist  (p_dist),
        .busy      (p_busy)
    );

    // Running minimum; a strictly smaller distance replaces the best so far.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_have_reg <= 1'b0;
        end else if (query_acc) begin
            best_have_reg <= 1'b0;
        end else if (p_valid) begin
            best_have_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_valid && (!best_have_reg || p_dist < best_d_reg)) begin
            best_idx_reg <= p_idx;
            best_sx_reg  <= p_sx;
            best_sy_reg  <= p_sy;
            best_ex_reg  <= p_ex;
            best_ey_reg  <= p_ey;
            best_d_reg   <= p_dist;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_result) begin
            m_found_reg <= best_have_reg;
            if (best_have_reg) begin
                m_idx_reg <= nss_pkg::INDEX_BITS'(best_idx_reg);
                m_sx_reg  <= best_sx_reg;
                m_sy_reg  <= best_sy_reg;
                m_ex_reg  <= best_ex_reg;
                m_ey_reg  <= best_ey_reg;
                m_d_reg   <= best_d_reg;
            end else begin
                m_idx_reg <= '0;
                m_sx_reg  <= '0;
                m_sy_reg  <= '0;
                m_ex_reg  <= '0;
                m_ey_reg  <= '0;
                m_d_reg   <= '0;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_found            = m_found_reg;
    assign m_best_index       = m_idx_reg;
    assign m_best_start_x     = m_sx_reg;
    assign m_best_start_y     = m_sy_reg;
    assign m_best_end_x       = m_ex_reg;
    assign m_best_end_y       = m_ey_reg;
    assign m_best_distance_sq = m_d_reg;

    // The distance pipeline only produces while a query is in flight.
    a_pipe_in_query: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid |-> (state_reg == nss_pkg::ST_ISSUE || state_reg == nss_pkg::ST_DRAIN))
        else $error("distance pipeline output outside a query");

    // An empty search result only comes from a zero entry count.
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nss_pkg::ST_FINISH && !best_have_reg) |-> (n_reg == '0))
        else $error("no best entry after a non-empty search");

    // A new result appears only when leaving the finish state.
    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == nss_pkg::ST_FINISH))
        else $error("result raised outside the finish state");

endmodule
